/* hdl/swbd_pkg.sv */
// Shared types and constants for the short-window back-reference decoder.
package swbd_pkg;

    localparam int BYTE_W     = 8;
    localparam int HIST_DEPTH = 32;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int COUNT_W    = 3;

    localparam logic [BYTE_W-1:0] ESCAPE_CODE = 8'hFF;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_COPY
    } state_t;

endpackage

/* hdl/short_window_backref_decoder.sv */
// Top level of the short-window back-reference decoder (32-byte history window).
//
// Input: a new code byte is taken only while idle, so none is taken during a copy.
// Output: a literal gives one byte, a copy code (code & 7) + 1 bytes, an escape none;
// the sequencer emits one byte per cycle while the output register is free or drains.
// Reset: rst_n clears the sequencer, escape flag, output valid and all 32 history bytes.
module short_window_backref_decoder (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [swbd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,   // last_in

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swbd_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                        m_tuser,   // [0] run_last
    output logic                        m_tlast    // chunk_last
);

    // Sequencer state
    swbd_pkg::state_t                  state_reg, state_next;
    logic [swbd_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [swbd_pkg::BYTE_W-1:0]       code_reg, code_next;
    logic                              last_reg, last_next;
    logic                              lit_reg, lit_next;
    logic                              esc_reg, esc_next;

    // History: newest byte at entry 0, shifted on every emitted byte
    logic [swbd_pkg::BYTE_W-1:0]       hist_reg  [swbd_pkg::HIST_DEPTH];
    logic [swbd_pkg::BYTE_W-1:0]       hist_next [swbd_pkg::HIST_DEPTH];

    // Output register
    logic                              m_valid_reg, m_valid_next;
    logic [swbd_pkg::BYTE_W-1:0]       m_data_reg, m_data_next;
    logic                              m_run_reg, m_run_next;
    logic                              m_chunk_reg, m_chunk_next;

    logic                              in_fire;
    logic                              emit;
    logic                              final_byte;
    logic                              is_escape;
    logic [swbd_pkg::HIST_AW-1:0]      src_idx;
    logic [swbd_pkg::BYTE_W-1:0]       emit_byte;

    // Control outputs of the sequencer
    always_comb
    begin
        s_tready   = (state_reg == swbd_pkg::ST_IDLE);
        in_fire    = s_tvalid && s_tready;
        // Emit only when the output register is free or drains this cycle
        emit       = (state_reg == swbd_pkg::ST_COPY) && (!m_valid_reg || m_tready);
        final_byte = emit && (count_reg == '0);
        is_escape  = !esc_reg && (s_tdata == swbd_pkg::ESCAPE_CODE);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swbd_pkg::ST_IDLE:
            begin
                if (in_fire && !is_escape)
                begin
                    state_next = swbd_pkg::ST_COPY;
                end
            end
            swbd_pkg::ST_COPY:
            begin
                if (final_byte)
                begin
                    state_next = swbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swbd_pkg::ST_IDLE;
            end
        endcase
    end

    // Source of a copy sits 32 - (code >> 3) bytes back, i.e. entry 31 - (code >> 3)
    assign src_idx   = ~code_reg[swbd_pkg::BYTE_W-1 -: swbd_pkg::HIST_AW];
    assign emit_byte = lit_reg ? code_reg : hist_reg[src_idx];

    // Datapath
    always_comb
    begin
        count_next   = count_reg;
        code_next    = code_reg;
        last_next    = last_reg;
        lit_next     = lit_reg;
        esc_next     = esc_reg;
        hist_next    = hist_reg;
        m_data_next  = m_data_reg;
        m_run_next   = m_run_reg;
        m_chunk_next = m_chunk_reg;

        // Drop the held transfer once taken; reload below if a byte is emitted
        m_valid_next = m_valid_reg && !m_tready;

        if (in_fire)
        begin
            code_next = s_tdata;
            last_next = s_tlast;
            if (esc_reg)
            begin
                // Literal after an escape: one byte, taken as is
                esc_next   = 1'b0;
                lit_next   = 1'b1;
                count_next = '0;
            end
            else if (is_escape)
            begin
                // Escape: arm the flag; a dangling escape at chunk end is dropped
                esc_next = !s_tlast;
                if (s_tlast)
                begin
                    for (int i = 0; i < swbd_pkg::HIST_DEPTH; i++)
                    begin
                        hist_next[i] = '0;
                    end
                end
            end
            else
            begin
                lit_next   = 1'b0;
                count_next = s_tdata[swbd_pkg::COUNT_W-1:0];
            end
        end

        if (emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = emit_byte;
            m_run_next   = final_byte;
            m_chunk_next = final_byte && last_reg;
            count_next   = count_reg - 1'b1;
            // Advance the history shift line
            for (int i = 1; i < swbd_pkg::HIST_DEPTH; i++)
            begin
                hist_next[i] = hist_reg[i-1];
            end
            hist_next[0] = emit_byte;
            // Chunk end: wipe history after its final byte
            if (final_byte && last_reg)
            begin
                esc_next = 1'b0;
                for (int i = 0; i < swbd_pkg::HIST_DEPTH; i++)
                begin
                    hist_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= swbd_pkg::ST_IDLE;
            esc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < swbd_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            esc_reg     <= esc_next;
            m_valid_reg <= m_valid_next;
            hist_reg    <= hist_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        code_reg    <= code_next;
        last_reg    <= last_next;
        lit_reg     <= lit_next;
        m_data_reg  <= m_data_next;
        m_run_reg   <= m_run_next;
        m_chunk_reg <= m_chunk_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_run_reg;
    assign m_tlast  = m_chunk_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the short-window back-reference decoder.
`timescale 1ns / 100ps

module tb_top;

    localparam int BYTE_W     = swbd_pkg::BYTE_W;
    localparam int HIST_DEPTH = swbd_pkg::HIST_DEPTH;
    localparam int COUNT_W    = swbd_pkg::COUNT_W;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE = swbd_pkg::ESCAPE_CODE;

    // Cycles with no transfer on either side before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;
    // Cycles to keep watching after the last expected byte has arrived.
    localparam int DRAIN_CYCLES  = 20;
    // Approximate size of the random part, in compressed bytes.
    localparam int RANDOM_TARGET = 230;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    // One decoded byte with its two end markers.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
        logic              chunk_last;
    } decoded_t;

    // Scoreboard: mirrors the window and escape state, queues the expected output.
    class backref_scoreboard;
        logic [BYTE_W-1:0] window_q [HIST_DEPTH];   // newest byte at entry 0
        bit                escape_due;
        decoded_t          due_q [$];
        int                errors;

        function new();
            clear_window();
            errors = 0;
        endfunction

        function void clear_window();
            foreach (window_q[i])
                window_q[i] = '0;
            escape_due = 1'b0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Queue one decoded byte and shift it into the window.
        function void emit_byte(logic [BYTE_W-1:0] b);
            decoded_t r;
            r.data       = b;
            r.run_last   = 1'b0;
            r.chunk_last = 1'b0;
            due_q.push_back(r);
            for (int i = HIST_DEPTH - 1; i > 0; i--)
                window_q[i] = window_q[i-1];
            window_q[0] = b;
        endfunction

        // Work out what one accepted compressed byte decodes to.
        function void note_input(logic [BYTE_W-1:0] code, logic last);
            int       base;
            int       count;
            int       back_dist;
            decoded_t r;
            base = due_q.size();
            if (escape_due)
            begin
                escape_due = 1'b0;
                emit_byte(code);
            end
            else if (code == ESCAPE_CODE)
            begin
                escape_due = 1'b1;
            end
            else
            begin
                count     = int'(code[COUNT_W-1:0]) + 1;
                back_dist = HIST_DEPTH - int'(code[BYTE_W-1:COUNT_W]);
                // Re-read the window every step so overlapping copies repeat fresh bytes.
                for (int j = 0; j < count; j++)
                    emit_byte(window_q[back_dist-1]);
            end
            if (due_q.size() > base)
            begin
                r            = due_q[due_q.size()-1];
                r.run_last   = 1'b1;
                r.chunk_last = last;
                due_q[due_q.size()-1] = r;
            end
            if (last)
                clear_window();
        endfunction

        // Compare one decoded byte against the oldest expectation.
        function void check_result(logic [BYTE_W-1:0] d, logic rl, logic cl);
            decoded_t e;
            if (due_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output byte %h (run_last %b, chunk_last %b)",
                         $time, d, rl, cl);
                return;
            end
            e = due_q.pop_front();
            if (d !== e.data)
            begin
                errors++;
                $display("%0t: out_byte mismatch, expected %h, actual %h", $time, e.data, d);
            end
            if (rl !== e.run_last)
            begin
                errors++;
                $display("%0t: run_last mismatch, expected %b, actual %b",
                         $time, e.run_last, rl);
            end
            if (cl !== e.chunk_last)
            begin
                errors++;
                $display("%0t: chunk_last mismatch, expected %b, actual %b",
                         $time, e.chunk_last, cl);
            end
        endfunction
    endclass

    backref_scoreboard sb;

    int bytes_fed;
    int directed_fed;
    int bytes_decoded;
    int chunks_closed;
    int idle_cycles;
    bit calm;   // when set, neither side inserts gaps

    short_window_backref_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] data_byte
        .s_tlast  (s_tlast),    // last_in
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tuser  (m_tuser),    // [0] run_last
        .m_tlast  (m_tlast)     // chunk_last
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Build a copy code from a distance (1..32) and a byte count (1..8).
    function automatic logic [BYTE_W-1:0] copy_code(int back_dist, int count);
        logic [BYTE_W-COUNT_W-1:0] back;
        logic [COUNT_W-1:0]        len;
        back = (BYTE_W-COUNT_W)'(HIST_DEPTH - back_dist);
        len  = COUNT_W'(count - 1);
        return {back, len};
    endfunction

    // Offer one compressed byte after a random gap and hold it until the transfer.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(b, last);
        bytes_fed++;
        if (last)
            chunks_closed++;
    endtask

    // Send an escape and the literal that follows it.
    task automatic send_literal(input logic [BYTE_W-1:0] b, input logic last);
        send_byte(ESCAPE_CODE, 1'b0);
        send_byte(b, last);
    endtask

    // Send one random chunk: mostly well-formed escape pairs and copy codes,
    // with some raw noise and now and then an escape left dangling at the end.
    task automatic send_random_chunk();
        logic [BYTE_W-1:0] chunk_q [$];
        int                len;
        int                r;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 12);
        while (chunk_q.size() < len)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                chunk_q.push_back(ESCAPE_CODE);
                chunk_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            else if (r < 90)
                chunk_q.push_back(BYTE_W'($urandom_range(0, 254)));
            else
                chunk_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0)
            chunk_q.push_back(ESCAPE_CODE);
        foreach (chunk_q[i])
            send_byte(chunk_q[i], i == chunk_q.size() - 1);
    endtask

    // Receiver: raise and drop tready at random, with calm stretches.
    initial
    begin
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready   = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Check every output transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
            bytes_decoded++;
        end
    end

    // Watchdog: stop the run if neither side moves for too long.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d bytes still expected",
                 $time, STALL_LIMIT, sb.pending());
        $display("short_window_backref_decoder test failed");
        $finish;
    end

    initial
    begin
        sb            = new();
        bytes_fed     = 0;
        directed_fed  = 0;
        bytes_decoded = 0;
        chunks_closed = 0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Copy straight out of the cleared history first.
        send_byte(copy_code(HIST_DEPTH, 1), 1'b0);
        // Literals, including the escape value itself and zero.
        send_literal(8'hA5, 1'b0);
        send_literal(ESCAPE_CODE, 1'b0);
        send_literal(8'h00, 1'b0);
        // Overlapping copy: distance 3, eight bytes repeat the last three.
        send_byte(copy_code(3, 8), 1'b0);
        // Highest copy code below the escape: distance 1, seven bytes.
        send_byte(copy_code(1, 7), 1'b0);
        // Farthest reach with the longest run.
        send_byte(copy_code(HIST_DEPTH, 8), 1'b0);
        // Close the chunk on a literal.
        send_literal(8'h5A, 1'b1);
        // History must read zeros again after the chunk end.
        send_byte(copy_code(1, 1), 1'b0);
        send_byte(copy_code(16, 4), 1'b0);
        // Dangling escape at the chunk end: nothing comes out and the escape is dropped.
        send_byte(ESCAPE_CODE, 1'b1);
        send_literal(8'h80, 1'b0);
        // Close a chunk on a copy code.
        send_byte(copy_code(5, 2), 1'b1);
        directed_fed = bytes_fed;

        // Random part: chunks of varied length, some with no gaps at all.
        while (bytes_fed - directed_fed < RANDOM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            send_random_chunk();
        end
        calm = 1'b0;
        @(negedge clk);
        s_tvalid = 1'b0;

        // Drain: wait for every expected byte, then watch a little longer.
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected bytes never arrived", $time, sb.pending());
        end
        $display("Fed %0d compressed bytes (%0d directed) in %0d closed chunks,",
                 bytes_fed, directed_fed, chunks_closed);
        $display("checked %0d decoded bytes, %0d mismatches.", bytes_decoded, sb.errors);
        if (sb.errors == 0)
            $display("short_window_backref_decoder test passed");
        else
            $display("short_window_backref_decoder test failed");
        $finish;
    end

endmodule
